### rtl/core/assert_macros.svh
// assertion macros shared by the rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication check, sampled on the rising clock, off while reset is low
`define ASSERT_IMPLY(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error(msg);

`endif

### rtl/core/arp_pkg.sv
// shared types and constants of the address-resolution cache
// no dependencies; imported by controller, datapath and top level
`default_nettype none

package arp_pkg;

  // field widths
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned IP_W   = 32;
  localparam int unsigned MAC_W  = 48;
  localparam int unsigned AGE_W  = 16;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned CNT_W  = 5;

  // action codes
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TICK   = 2'd2;

  localparam logic [AGE_W-1:0] AGE_MAX     = {AGE_W{1'b1}};
  localparam logic [AGE_W-1:0] TIMEOUT_RST = 16'd15;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture request, restart scan
    logic rd_en;  // read one entry and step the scan index
    logic push;   // hand the result to the output register
  } arp_cmd_t;

  // datapath and output stage to controller
  typedef struct packed {
    logic last;      // scan index sits on the final entry
    logic out_free;  // output register can take a result
  } arp_stat_t;

endpackage

`default_nettype wire

### rtl/core/arp_cache_table_top.sv
// top level of the address-resolution cache: ports, timeout register,
// output register; depends on arp_pkg, arp_ctrl, arp_dpath, assert_macros.svh
//
//   channel   direction  handshake                  payload
//   s_axis    in         s_axis_tvalid/tready       action, ip_addr, mac_addr
//   m_axis    out        m_axis_tvalid/tready       success .. expired_count
//   cfg       in         cfg_valid/cfg_ready        timeout_seconds
//
// each request is accepted, then every entry is read in turn through the
// registered read of the entry memories; the last read is drained and the
// output register is loaded.
// reset clears the valid bits at once; no clearing pass over the memories.
// a finished result waits in the output register while the next request
// is accepted; the sequencer holds in its last step until that register frees.
`default_nettype none
`include "assert_macros.svh"

module arp_cache_table_top #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // action [1:0], ip_addr [33:2], mac_addr [81:34], zero [87:82]
  input  wire logic [87:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // success [0], slot [4:1], mac_found [52:5], entry_age [68:53],
  // expired_count [73:69], zero [79:74]
  output logic [79:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);
  import arp_pkg::*;

  arp_cmd_t  cmd;
  arp_stat_t stat;
  logic      last;

  logic [AGE_W-1:0] timeout_q;

  logic              res_success;
  logic [SLOT_W-1:0] res_slot;
  logic [MAC_W-1:0]  res_mac;
  logic [AGE_W-1:0]  res_age;
  logic [CNT_W-1:0]  res_cnt;

  logic              out_vld_q;
  logic              out_success_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic [MAC_W-1:0]  out_mac_q;
  logic [AGE_W-1:0]  out_age_q;
  logic [CNT_W-1:0]  out_cnt_q;

  // timeout register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
    end else if (cfg_valid_i) begin
      timeout_q <= cfg_data_i;
    end
  end

  // status toward the sequencer
  assign stat.last     = last;
  assign stat.out_free = !out_vld_q || m_axis_tready;

  arp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  arp_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .last_o          (last),
    .action_i        (s_axis_tdata[1:0]),
    .ip_addr_i       (s_axis_tdata[33:2]),
    .mac_addr_i      (s_axis_tdata[81:34]),
    .timeout_i       (timeout_q),
    .success_o       (res_success),
    .slot_o          (res_slot),
    .mac_found_o     (res_mac),
    .entry_age_o     (res_age),
    .expired_count_o (res_cnt)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd.push) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.push) begin
      out_success_q <= res_success;
      out_slot_q    <= res_slot;
      out_mac_q     <= res_mac;
      out_age_q     <= res_age;
      out_cnt_q     <= res_cnt;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_cnt_q, out_age_q, out_mac_q, out_slot_q, out_success_q};

  // checks
  `ASSERT_IMPLY(a_push_free, clk_i, rst_ni, cmd.push, !out_vld_q || m_axis_tready, "result pushed over a pending one")
  `ASSERT_IMPLY(a_accept_load, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, cmd.load, "request accepted without a load command")
  `ASSERT_NEVER(a_tick_no_hit, clk_i, rst_ni, out_vld_q && (out_cnt_q != '0) && out_success_q, "expired entries reported with success")

endmodule

`default_nettype wire

### rtl/core/arp_ctrl.sv
// sequencer of the address-resolution cache: accept, scan, drain, push
// depends on arp_pkg for the command and status structs
`default_nettype none

module arp_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               req_valid_i,
  output logic                    req_ready_o,
  input  wire arp_pkg::arp_stat_t stat_i,
  output arp_pkg::arp_cmd_t       cmd_o
);
  import arp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_PUSH  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (stat_i.last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_PUSH;
      end
      S_PUSH: begin
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/arp_dpath.sv
// datapath of the address-resolution cache: entry memories, valid bits,
// scan index and result accumulators; depends on arp_pkg
`default_nettype none

module arp_dpath #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire arp_pkg::arp_cmd_t           cmd_i,
  output logic                             last_o,
  input  wire logic [arp_pkg::ACT_W-1:0]   action_i,
  input  wire logic [arp_pkg::IP_W-1:0]    ip_addr_i,
  input  wire logic [arp_pkg::MAC_W-1:0]   mac_addr_i,
  input  wire logic [arp_pkg::AGE_W-1:0]   timeout_i,
  output logic                             success_o,
  output logic [arp_pkg::SLOT_W-1:0]       slot_o,
  output logic [arp_pkg::MAC_W-1:0]        mac_found_o,
  output logic [arp_pkg::AGE_W-1:0]        entry_age_o,
  output logic [arp_pkg::CNT_W-1:0]        expired_count_o
);
  import arp_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

  // captured request
  logic [ACT_W-1:0] act_q;
  logic [IP_W-1:0]  ip_q;
  logic [MAC_W-1:0] mac_q;

  // scan index and read pipeline
  logic [IDX_W-1:0] idx_q, idx_p_q;
  logic             proc_q;

  // entry storage
  logic [ENTRIES-1:0] vld_q;
  logic [IP_W-1:0]    ip_mem  [ENTRIES];
  logic [MAC_W-1:0]   mac_mem [ENTRIES];
  logic [AGE_W-1:0]   age_mem [ENTRIES];
  logic [IP_W-1:0]    ip_rd_q;
  logic [MAC_W-1:0]   mac_rd_q;
  logic [AGE_W-1:0]   age_rd_q;

  // accumulators
  logic             hit_q;
  logic [IDX_W-1:0] slot_q;
  logic [MAC_W-1:0] mac_res_q;
  logic [AGE_W-1:0] age_res_q;
  logic [CNT_W-1:0] cnt_q;

  logic             vld_cur;
  logic [AGE_W-1:0] age_inc;
  logic             look_hit, ins_we, tick_we, expire;

  assign last_o = (idx_q == IDX_LAST);

  // per-entry decisions on the entry read in the previous cycle
  assign vld_cur  = vld_q[idx_p_q];
  assign age_inc  = (age_rd_q == AGE_MAX) ? age_rd_q : age_rd_q + 1'b1;
  assign look_hit = proc_q && (act_q == ACT_LOOKUP) && vld_cur && (ip_rd_q == ip_q);
  assign ins_we   = proc_q && (act_q == ACT_INSERT) && !hit_q && !vld_cur;
  assign tick_we  = proc_q && (act_q == ACT_TICK) && vld_cur;
  assign expire   = tick_we && (age_inc > timeout_i);

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_i;
      ip_q  <= ip_addr_i;
      mac_q <= mac_addr_i;
    end
  end

  // scan index
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q <= '0;
    end else if (cmd_i.rd_en && !last_o) begin
      idx_q <= idx_q + 1'b1;
    end
    if (cmd_i.rd_en) begin
      idx_p_q <= idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_q <= 1'b0;
    end else begin
      proc_q <= cmd_i.rd_en;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ins_we) begin
      vld_q[idx_p_q] <= 1'b1;
    end else if (expire) begin
      vld_q[idx_p_q] <= 1'b0;
    end
  end

  // address memory
  always_ff @(posedge clk_i) begin
    if (ins_we) begin
      ip_mem[idx_p_q] <= ip_q;
    end
    if (cmd_i.rd_en) begin
      ip_rd_q <= ip_mem[idx_q];
    end
  end

  // hardware address memory
  always_ff @(posedge clk_i) begin
    if (ins_we) begin
      mac_mem[idx_p_q] <= mac_q;
    end
    if (cmd_i.rd_en) begin
      mac_rd_q <= mac_mem[idx_q];
    end
  end

  // age memory, cleared on insert and bumped on tick
  always_ff @(posedge clk_i) begin
    if (ins_we || tick_we) begin
      age_mem[idx_p_q] <= ins_we ? '0 : age_inc;
    end
    if (cmd_i.rd_en) begin
      age_rd_q <= age_mem[idx_q];
    end
  end

  // result accumulators, later hits overwrite earlier ones
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hit_q     <= 1'b0;
      slot_q    <= '0;
      mac_res_q <= '0;
      age_res_q <= '0;
      cnt_q     <= '0;
    end else begin
      if (look_hit) begin
        hit_q     <= 1'b1;
        slot_q    <= idx_p_q;
        mac_res_q <= mac_rd_q;
        age_res_q <= age_rd_q;
      end
      if (ins_we) begin
        hit_q  <= 1'b1;
        slot_q <= idx_p_q;
      end
      if (expire) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  assign success_o       = hit_q;
  assign slot_o          = SLOT_W'(slot_q);
  assign mac_found_o     = mac_res_q;
  assign entry_age_o     = age_res_q;
  assign expired_count_o = cnt_q;

endmodule

`default_nettype wire
